[design/vtc_pkg.sv]
// ----------------------------------------------------------------------------
// vtc_pkg
// Shared opcodes, status codes, defaults and the control word that moves
// down the cell chain of the value table.
// ----------------------------------------------------------------------------
package vtc_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int VALUE_BITS_DEF = 16;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_COUNT  = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	// control part of a request as it walks the chain
	typedef struct packed {
		logic       vld;
		logic [1:0] op;
		logic       placed;
		logic       present;
	} vtc_ctl_t;

endpackage

[design/vtc_cell.sv]
// ----------------------------------------------------------------------------
// vtc_cell
// One table slot. Applies a passing request to its own entry, adds its
// share to the running counts and maximum, and registers it for the next.
// ----------------------------------------------------------------------------
module vtc_cell #(
	parameter int VALUE_BITS = vtc_pkg::VALUE_BITS_DEF,
	parameter int CNT_W      = 5,
	parameter int IDX_W      = 4,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  vtc_pkg::vtc_ctl_t     ctl_i,
	input  logic [VALUE_BITS-1:0] value_i,
	input  logic [CNT_W-1:0]      match_i,
	input  logic [IDX_W-1:0]      slot_i,
	input  logic [CNT_W-1:0]      cnt_i,
	input  logic [VALUE_BITS-1:0] max_i,
	output vtc_pkg::vtc_ctl_t     ctl_o,
	output logic [VALUE_BITS-1:0] value_o,
	output logic [CNT_W-1:0]      match_o,
	output logic [IDX_W-1:0]      slot_o,
	output logic [CNT_W-1:0]      cnt_o,
	output logic [VALUE_BITS-1:0] max_o
);
	import vtc_pkg::*;

	logic [VALUE_BITS-1:0] entry_q;
	logic                  entry_vld_q;

	vtc_ctl_t              ctl_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CNT_W-1:0]      match_q;
	logic [IDX_W-1:0]      slot_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] max_q;

	logic                  hit;
	logic                  do_ins;
	logic                  do_del;
	logic                  new_vld;
	logic [VALUE_BITS-1:0] new_entry;
	logic                  take_max;

	always_comb begin
		hit       = entry_vld_q && (entry_q == value_i);
		do_ins    = ctl_i.vld && (ctl_i.op == OP_INSERT) && !ctl_i.placed && !entry_vld_q;
		do_del    = ctl_i.vld && (ctl_i.op == OP_DELETE) && hit;
		new_vld   = do_ins ? 1'b1 : (do_del ? 1'b0 : entry_vld_q);
		new_entry = do_ins ? value_i : entry_q;
		take_max  = new_vld && (!ctl_i.present || (new_entry > max_i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= 1'b0;
			ctl_q       <= '0;
		end else if (adv) begin
			entry_vld_q    <= new_vld;
			ctl_q.vld      <= ctl_i.vld;
			ctl_q.op       <= ctl_i.op;
			ctl_q.placed   <= ctl_i.placed | do_ins;
			ctl_q.present  <= ctl_i.present | new_vld;
		end
	end

	// entry and carried payload need no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			if (do_ins) begin
				entry_q <= value_i;
			end
			value_q <= value_i;
			match_q <= match_i + CNT_W'(hit);
			slot_q  <= do_ins ? IDX_W'(INDEX) : slot_i;
			cnt_q   <= cnt_i + CNT_W'(new_vld);
			max_q   <= take_max ? new_entry : max_i;
		end
	end

	assign ctl_o   = ctl_q;
	assign value_o = value_q;
	assign match_o = match_q;
	assign slot_o  = slot_q;
	assign cnt_o   = cnt_q;
	assign max_o   = max_q;

endmodule

[design/value_table_insert_delete_count.sv]
// ----------------------------------------------------------------------------
// value_table_insert_delete_count
// Value table with insert, delete-all-equal and count, built as a chain of
// one cell per slot that each request walks through in order.
// Each cell registers a request as it passes; the last holds the result.
// Throughput: one request per cycle, up to SLOTS in the chain, when not
// stalled; a stalled result freezes the whole chain until it is taken.
// Reset empties the table (all slot valid bits cleared) and the chain.
// ----------------------------------------------------------------------------
module value_table_insert_delete_count #(
	parameter int SLOTS      = vtc_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = vtc_pkg::VALUE_BITS_DEF,
	parameter int CNT_W      = $clog2(SLOTS + 1),
	parameter int IDX_W      = $clog2(SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            opcode,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [CNT_W-1:0]      match_count,
	output logic [IDX_W-1:0]      slot_used,
	output logic [CNT_W-1:0]      valid_count,
	output logic [VALUE_BITS-1:0] max_value,
	output logic                  max_present
);
	import vtc_pkg::*;

	vtc_ctl_t              ctl   [SLOTS+1];
	logic [VALUE_BITS-1:0] val   [SLOTS+1];
	logic [CNT_W-1:0]      match [SLOTS+1];
	logic [IDX_W-1:0]      slot  [SLOTS+1];
	logic [CNT_W-1:0]      cnt   [SLOTS+1];
	logic [VALUE_BITS-1:0] maxv  [SLOTS+1];

	logic adv;

	// last cell's register is the output register
	assign adv       = !ctl[SLOTS].vld || out_ready;
	assign in_ready  = adv;
	assign out_valid = ctl[SLOTS].vld;

	always_comb begin
		ctl[0].vld     = in_valid;
		ctl[0].op      = opcode;
		ctl[0].placed  = 1'b0;
		ctl[0].present = 1'b0;
		val[0]         = value;
		match[0]       = '0;
		slot[0]        = '0;
		cnt[0]         = '0;
		maxv[0]        = '0;
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		vtc_cell #(
			.VALUE_BITS (VALUE_BITS),
			.CNT_W      (CNT_W),
			.IDX_W      (IDX_W),
			.INDEX      (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_i   (ctl[i]),
			.value_i (val[i]),
			.match_i (match[i]),
			.slot_i  (slot[i]),
			.cnt_i   (cnt[i]),
			.max_i   (maxv[i]),
			.ctl_o   (ctl[i+1]),
			.value_o (val[i+1]),
			.match_o (match[i+1]),
			.slot_o  (slot[i+1]),
			.cnt_o   (cnt[i+1]),
			.max_o   (maxv[i+1])
		);
	end

	always_comb begin
		if ((ctl[SLOTS].op == OP_INSERT) && !ctl[SLOTS].placed) begin
			status = ST_FULL;
		end else if ((ctl[SLOTS].op == OP_DELETE) && (match[SLOTS] == '0)) begin
			status = ST_NOMATCH;
		end else begin
			status = ST_DONE;
		end
	end

	assign match_count = match[SLOTS];
	assign slot_used   = slot[SLOTS];
	assign valid_count = cnt[SLOTS];
	assign max_value   = maxv[SLOTS];
	assign max_present = ctl[SLOTS].present;

endmodule

[verif/value_table_checker.sv]
// ----------------------------------------------------------------------------
// value_table_checker
// Watches both channels of the value table. Every accepted request is run
// through a software copy of the table to predict its result, and every
// accepted result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module value_table_checker #(
	parameter int SLOTS      = vtc_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = vtc_pkg::VALUE_BITS_DEF,
	parameter int CNT_W      = $clog2(SLOTS + 1),
	parameter int IDX_W      = $clog2(SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [1:0]            opcode,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [1:0]            status,
	input  logic [CNT_W-1:0]      match_count,
	input  logic [IDX_W-1:0]      slot_used,
	input  logic [CNT_W-1:0]      valid_count,
	input  logic [VALUE_BITS-1:0] max_value,
	input  logic                  max_present,
	output int                    mismatches,
	output int                    outstanding,
	output int                    results_seen,
	output int                    full_inserts,
	output int                    unmatched_deletes
);
	import vtc_pkg::*;

	typedef struct packed {
		logic [1:0]            status;
		logic [CNT_W-1:0]      match_count;
		logic [IDX_W-1:0]      slot_used;
		logic [CNT_W-1:0]      valid_count;
		logic [VALUE_BITS-1:0] max_value;
		logic                  max_present;
	} table_result_t;

	logic [VALUE_BITS-1:0] slot_val [SLOTS];
	logic                  slot_vld [SLOTS];
	table_result_t         expected_results [$];

	function automatic table_result_t apply_request(logic [1:0] op,
		logic [VALUE_BITS-1:0] v);
		table_result_t r;
		int hits;
		int occupied;
		bit placed;
		hits     = 0;
		occupied = 0;
		placed   = 0;
		r        = '0;
		for (int i = 0; i < SLOTS; i++)
			if (slot_vld[i] && slot_val[i] == v)
				hits++;
		r.match_count = hits[CNT_W-1:0];
		r.status      = ST_DONE;
		case (op)
			OP_INSERT: begin
				for (int i = 0; i < SLOTS; i++)
					if (!placed && !slot_vld[i]) begin
						slot_val[i] = v;
						slot_vld[i] = 1'b1;
						r.slot_used = i[IDX_W-1:0];
						placed      = 1;
					end
				if (!placed)
					r.status = ST_FULL;
			end
			OP_DELETE: begin
				if (hits == 0)
					r.status = ST_NOMATCH;
				else
					for (int i = 0; i < SLOTS; i++)
						if (slot_vld[i] && slot_val[i] == v)
							slot_vld[i] = 1'b0;
			end
			// count and the unused opcode leave the table alone
			default: ;
		endcase
		for (int i = 0; i < SLOTS; i++)
			if (slot_vld[i]) begin
				occupied++;
				if (!r.max_present || slot_val[i] > r.max_value)
					r.max_value = slot_val[i];
				r.max_present = 1'b1;
			end
		r.valid_count = occupied[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		table_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_val[i] = '0;
				slot_vld[i] = 1'b0;
			end
			expected_results.delete();
			mismatches        <= 0;
			outstanding       <= 0;
			results_seen      <= 0;
			full_inserts      <= 0;
			unmatched_deletes <= 0;
		end else begin
			if (in_valid && in_ready) begin
				want = apply_request(opcode, value);
				if (want.status == ST_FULL)
					full_inserts <= full_inserts + 1;
				if (want.status == ST_NOMATCH)
					unmatched_deletes <= unmatched_deletes + 1;
				expected_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					mismatches <= mismatches + 1;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status ||
						match_count !== want.match_count ||
						slot_used !== want.slot_used ||
						valid_count !== want.valid_count ||
						max_value !== want.max_value ||
						max_present !== want.max_present)
						mismatches <= mismatches + 1;
					if (status !== want.status)
						$error("status expected %0d got %0d", want.status, status);
					if (match_count !== want.match_count)
						$error("match_count expected %0d got %0d",
							want.match_count, match_count);
					if (slot_used !== want.slot_used)
						$error("slot_used expected %0d got %0d", want.slot_used, slot_used);
					if (valid_count !== want.valid_count)
						$error("valid_count expected %0d got %0d",
							want.valid_count, valid_count);
					if (max_value !== want.max_value)
						$error("max_value expected %h got %h", want.max_value, max_value);
					if (max_present !== want.max_present)
						$error("max_present expected %0d got %0d",
							want.max_present, max_present);
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

[verif/value_table_insert_delete_count_test.sv]
// ----------------------------------------------------------------------------
// value_table_insert_delete_count_test
// Drives directed and random insert, delete and count requests into the
// value table under three idle mixes and a long result stall, and reports
// the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
module value_table_insert_delete_count_test;
	import vtc_pkg::*;

	localparam int SLOTS       = SLOTS_DEF;
	localparam int VALUE_BITS  = VALUE_BITS_DEF;
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int IDX_W       = $clog2(SLOTS);
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int PHASE_REQS  = 475;
	localparam int HOLD_CYCLES = 120;
	localparam int STALL_LIMIT = 3000;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [1:0]            opcode      = OP_COUNT;
	logic [VALUE_BITS-1:0] value       = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [1:0]            status;
	logic [CNT_W-1:0]      match_count;
	logic [IDX_W-1:0]      slot_used;
	logic [CNT_W-1:0]      valid_count;
	logic [VALUE_BITS-1:0] max_value;
	logic                  max_present;

	int mismatches;
	int outstanding;
	int results_seen;
	int full_inserts;
	int unmatched_deletes;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int sent_count    = 0;
	int stall_cycles  = 0;
	bit hold_done     = 0;
	logic [VALUE_BITS-1:0] value_pool [6];

	value_table_insert_delete_count DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .match_count(match_count), .slot_used(slot_used),
		.valid_count(valid_count), .max_value(max_value), .max_present(max_present)
	);

	value_table_checker #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .match_count(match_count), .slot_used(slot_used),
		.valid_count(valid_count), .max_value(max_value), .max_present(max_present),
		.mismatches(mismatches), .outstanding(outstanding),
		.results_seen(results_seen), .full_inserts(full_inserts),
		.unmatched_deletes(unmatched_deletes)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// result side: random back-pressure plus one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && sent_count >= 60) begin
				hold_done = 1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_request(logic [1:0] op, logic [VALUE_BITS-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		value    <= v;
		do
			@(posedge clk);
		while (!in_ready);
		sent_count++;
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value();
		if ($urandom_range(99) < 75)
			return value_pool[$urandom_range(5)];
		return VALUE_BITS'($urandom());
	endfunction

	// grow regimes favor inserts, shrink regimes favor deletes
	function automatic logic [1:0] pick_opcode(bit grow);
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return OP_UNUSED;
		if (r < 25)
			return OP_COUNT;
		if (grow)
			return (r < 90) ? OP_INSERT : OP_DELETE;
		return (r < 40) ? OP_INSERT : OP_DELETE;
	endfunction

	initial begin
		bit grow;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 10;
		recv_idle_pct = 53;

		// empty table, missed delete, duplicates, unused opcode
		send_request(OP_COUNT, 16'h0000);
		send_request(OP_DELETE, 16'h0000);
		send_request(OP_INSERT, 16'hFFFF);
		send_request(OP_INSERT, 16'h0000);
		send_request(OP_INSERT, 16'hFFFF);
		send_request(OP_COUNT, 16'hFFFF);
		send_request(OP_UNUSED, 16'h0000);
		send_request(OP_DELETE, 16'hFFFF);
		// fill the table, then overflow it
		for (int i = 0; i < SLOTS - 1; i++)
			send_request(OP_INSERT, 16'h0001 << i);
		send_request(OP_INSERT, 16'h1234);
		send_request(OP_DELETE, 16'h0000);
		send_request(OP_COUNT, 16'h0001);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 53;
				recv_idle_pct = 10;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			grow = 1;
			for (int n = 0; n < PHASE_REQS; n++) begin
				if (n % 150 == 0)
					for (int k = 0; k < 6; k++)
						value_pool[k] = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF :
							VALUE_BITS'($urandom());
				if (n % 40 == 0)
					grow = !grow;
				send_request(pick_opcode(grow), pick_value());
			end
		end
		in_valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (2 * SLOTS) @(posedge clk);

		$display("sent %0d requests over three idle mixes and one long result stall",
			sent_count);
		$display("checked %0d results: %0d full-table inserts, %0d unmatched deletes",
			results_seen, full_inserts, unmatched_deletes);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
